// ===== hw/rtl/bdq_pkg.sv =====
// Shared types and constants for the bounded deque with indexed read.
package bdq_pkg;

	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_READ       = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_UNDERFLOW = 2'd1,
		STAT_RANGE     = 2'd2,
		STAT_OVERFLOW  = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SHOW
	} state_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic exec;    // input beat accepted: update pointers, write store, issue read
		logic finish;  // store read data is valid: load result registers
	} ctl_t;

endpackage

// ===== hw/rtl/bdq_ctrl.sv =====
// Controller state machine: input/output handshake and sequencing of the datapath.
module bdq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output bdq_pkg::ctl_t   ctl
);

	bdq_pkg::state_t state_q;
	bdq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		out_valid  = 1'b0;
		ctl.exec   = 1'b0;
		ctl.finish = 1'b0;
		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				ctl.exec = in_valid;
				if (in_valid) begin
					state_d = bdq_pkg::ST_FETCH;
				end
			end
			bdq_pkg::ST_FETCH: begin
				ctl.finish = 1'b1;
				state_d    = bdq_pkg::ST_SHOW;
			end
			bdq_pkg::ST_SHOW: begin
				out_valid = 1'b1;
				// take the next beat in the same cycle the result leaves
				in_stall  = out_stall;
				if (!out_stall) begin
					ctl.exec = in_valid;
					state_d  = in_valid ? bdq_pkg::ST_FETCH : bdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bdq_pkg::ST_IDLE;
			end
		endcase
	end

	a_exec_to_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> state_q == bdq_pkg::ST_FETCH)
		else $error("accepted beat did not start a store read");

	a_fetch_to_show: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bdq_pkg::ST_FETCH |=> out_valid && !ctl.finish)
		else $error("result not presented after store read");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && !ctl.finish)
		else $error("stalled result dropped or overwritten");

endmodule

// ===== hw/rtl/bdq_datapath.sv =====
// Datapath: ring store, head pointer, count, cached ends and result registers.
module bdq_datapath #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bdq_pkg::ctl_t                      ctl,
	input  logic [bdq_pkg::CMD_W-1:0]          cmd,
	input  logic signed [DATA_WIDTH-1:0]       data,
	input  logic [bdq_pkg::POS_W-1:0]          position,
	output logic signed [DATA_WIDTH-1:0]       read_value,
	output logic signed [DATA_WIDTH-1:0]       front_value,
	output logic signed [DATA_WIDTH-1:0]       back_value,
	output logic [bdq_pkg::COUNT_W-1:0]        entry_count,
	output logic                               is_empty,
	output logic [bdq_pkg::STAT_W-1:0]         status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int OW = (CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W;
	localparam int SW = OW + 1;

	logic [AW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [DATA_WIDTH-1:0] store_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;
	logic [DATA_WIDTH-1:0] front_q;
	logic [DATA_WIDTH-1:0] back_q;
	logic [DATA_WIDTH-1:0] rdval_q;
	bdq_pkg::stat_t        status_q;
	logic                  want_rd_q;
	logic                  upd_front_q;
	logic                  upd_back_q;

	logic                  full;
	logic                  empty;
	logic [AW-1:0]         head_inc;
	logic [AW-1:0]         head_dec;
	logic [OW-1:0]         offset;
	logic [SW-1:0]         slot_sum;
	logic [AW-1:0]         slot_addr;
	logic [AW-1:0]         waddr;
	logic                  we;
	logic [AW-1:0]         head_d;
	logic [CW-1:0]         count_d;
	bdq_pkg::stat_t        stat_d;
	logic                  want_rd;
	logic                  upd_front;
	logic                  upd_back;
	logic                  set_front;
	logic                  set_back;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;

	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

	// ring slot at an offset from the front; the sum stays below twice the depth
	assign slot_sum  = SW'(head_q) + SW'(offset);
	assign slot_addr = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH)) : AW'(slot_sum);
	assign waddr     = (cmd == bdq_pkg::CMD_PUSH_FRONT) ? head_dec : slot_addr;

	always_comb begin
		offset    = '0;
		we        = 1'b0;
		head_d    = head_q;
		count_d   = count_q;
		stat_d    = bdq_pkg::STAT_OK;
		want_rd   = 1'b0;
		upd_front = 1'b0;
		upd_back  = 1'b0;
		set_front = 1'b0;
		set_back  = 1'b0;
		unique case (cmd)
			bdq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					stat_d = bdq_pkg::STAT_OVERFLOW;
				end else begin
					offset    = OW'(count_q);
					we        = 1'b1;
					count_d   = count_q + CW'(1);
					set_back  = 1'b1;
					set_front = empty;
				end
			end
			bdq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					stat_d = bdq_pkg::STAT_OVERFLOW;
				end else begin
					we        = 1'b1;
					head_d    = head_dec;
					count_d   = count_q + CW'(1);
					set_front = 1'b1;
					set_back  = empty;
				end
			end
			bdq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					stat_d = bdq_pkg::STAT_UNDERFLOW;
				end else begin
					count_d = count_q - CW'(1);
					// fetch the new back entry unless the queue drains
					if (count_q > CW'(1)) begin
						offset   = OW'(count_q - CW'(2));
						upd_back = 1'b1;
					end
				end
			end
			bdq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					stat_d = bdq_pkg::STAT_UNDERFLOW;
				end else begin
					head_d    = head_inc;
					count_d   = count_q - CW'(1);
					offset    = OW'(1);
					upd_front = count_q > CW'(1);
				end
			end
			bdq_pkg::CMD_READ: begin
				if (OW'(position) >= OW'(count_q)) begin
					stat_d = bdq_pkg::STAT_RANGE;
				end else begin
					offset  = OW'(position);
					want_rd = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctl.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && we) begin
			store_q[waddr] <= data;
		end
		rd_q <= store_q[slot_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q    <= stat_d;
			want_rd_q   <= want_rd;
			upd_front_q <= upd_front;
			upd_back_q  <= upd_back;
			if (set_front) begin
				front_q <= data;
			end
			if (set_back) begin
				back_q <= data;
			end
		end
		if (ctl.finish) begin
			rdval_q <= want_rd_q ? rd_q : '0;
			if (upd_front_q) begin
				front_q <= rd_q;
			end
			if (upd_back_q) begin
				back_q <= rd_q;
			end
		end
	end

	assign read_value  = $signed(rdval_q);
	assign front_value = empty ? '0 : $signed(front_q);
	assign back_value  = empty ? '0 : $signed(back_q);
	assign entry_count = bdq_pkg::COUNT_W'(count_q);
	assign is_empty    = empty;
	assign status      = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("held count exceeds depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(DEPTH - 1))
		else $error("head pointer outside the ring");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && !full && (cmd == bdq_pkg::CMD_PUSH_BACK ||
			cmd == bdq_pkg::CMD_PUSH_FRONT)) |=> count_q == $past(count_q) + CW'(1))
		else $error("push on a non-full queue did not add an entry");

endmodule

// ===== hw/rtl/bounded_deque_with_indexed_read.sv =====
// Bounded double-ended queue of signed words with indexed read.
//
// Input channel (in_valid / in_stall) carries one command beat: cmd, data
// (pushes only) and position (read only). Output channel (out_valid /
// out_stall) returns exactly one result beat per command: the read value,
// front and back entries after the command, entry count, empty flag and a
// status (ok, pop underflow, position out of range, push overflow).
// The entries sit in a DEPTH-word ring memory with one write and one
// registered read port; front and back are also kept in registers.
// After the accepting edge the controller passes through FETCH, where the
// registered ring memory read completes, and presents the result in SHOW.
// No new beat is taken during FETCH; while the receiver keeps out_stall
// low, a new beat is taken on the same edge a result leaves.
// When the receiver stalls, the result holds and no new beat is accepted.
// Reset (arst_n low) empties the queue and clears the handshake; the ring
// memory itself is not cleared and needs no clearing pass.
module bounded_deque_with_indexed_read #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bdq_pkg::CMD_W-1:0]     cmd,
	input  logic signed [DATA_WIDTH-1:0]  data,
	input  logic [bdq_pkg::POS_W-1:0]     position,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [DATA_WIDTH-1:0]  read_value,
	output logic signed [DATA_WIDTH-1:0]  front_value,
	output logic signed [DATA_WIDTH-1:0]  back_value,
	output logic [bdq_pkg::COUNT_W-1:0]   entry_count,
	output logic                          is_empty,
	output logic [bdq_pkg::STAT_W-1:0]    status
);

	bdq_pkg::ctl_t ctl;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	bdq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cmd         (cmd),
		.data        (data),
		.position    (position),
		.read_value  (read_value),
		.front_value (front_value),
		.back_value  (back_value),
		.entry_count (entry_count),
		.is_empty    (is_empty),
		.status      (status)
	);

endmodule

// ===== tb/tb_bounded_deque_with_indexed_read.sv =====
// Testbench for the bounded deque with indexed read: directed, fill, backpressure and random tests.
`timescale 1ns / 100ps

module tb_bounded_deque_with_indexed_read;

	localparam int DEPTH       = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;

	// Command codes the block must treat as no-ops.
	localparam logic [bdq_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [bdq_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

	localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = 32'sh80000000;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] rd;
		logic signed [DATA_WIDTH-1:0] front;
		logic signed [DATA_WIDTH-1:0] back;
		logic [bdq_pkg::COUNT_W-1:0]  cnt;
		logic                         empty;
		bdq_pkg::stat_t               st;
	} deque_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [bdq_pkg::CMD_W-1:0]    cmd;
	logic signed [DATA_WIDTH-1:0] data;
	logic [bdq_pkg::POS_W-1:0]    position;
	logic                         out_valid;
	logic                         out_stall;
	logic signed [DATA_WIDTH-1:0] read_value;
	logic signed [DATA_WIDTH-1:0] front_value;
	logic signed [DATA_WIDTH-1:0] back_value;
	logic [bdq_pkg::COUNT_W-1:0]  entry_count;
	logic                         is_empty;
	logic [bdq_pkg::STAT_W-1:0]   status;

	// Predicted queue contents.
	logic signed [DATA_WIDTH-1:0] ring [DEPTH];
	logic [bdq_pkg::POS_W-1:0]    mdl_head;
	logic [bdq_pkg::COUNT_W-1:0]  mdl_count;

	deque_result_t pending_results[$];

	int fail_count;
	int commands_sent;
	int results_checked;
	int status_seen [4];
	int peak_count;
	int send_idle_pct;
	int recv_idle_pct;
	int idle_cycles;
	int hold_requests;
	int holds_taken;
	int hold_left;

	bounded_deque_with_indexed_read #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.data(data),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_value(read_value),
		.front_value(front_value),
		.back_value(back_value),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.status(status)
	);

	always #5 clk = ~clk;

	// Apply one command to the predicted deque and return the result it yields.
	function automatic deque_result_t deque_step(logic [bdq_pkg::CMD_W-1:0] c,
			logic signed [DATA_WIDTH-1:0] d, logic [bdq_pkg::POS_W-1:0] p);
		deque_result_t r;
		logic [bdq_pkg::POS_W-1:0] slot;
		r.rd = '0;
		r.st = bdq_pkg::STAT_OK;
		case (c)
			bdq_pkg::CMD_PUSH_BACK: begin
				if (mdl_count == DEPTH) begin
					r.st = bdq_pkg::STAT_OVERFLOW;
				end else begin
					slot = mdl_head + mdl_count[bdq_pkg::POS_W-1:0];
					ring[slot] = d;
					mdl_count++;
				end
			end
			bdq_pkg::CMD_PUSH_FRONT: begin
				if (mdl_count == DEPTH) begin
					r.st = bdq_pkg::STAT_OVERFLOW;
				end else begin
					mdl_head = mdl_head - 1'b1;
					ring[mdl_head] = d;
					mdl_count++;
				end
			end
			bdq_pkg::CMD_POP_BACK: begin
				if (mdl_count == 0) r.st = bdq_pkg::STAT_UNDERFLOW;
				else mdl_count--;
			end
			bdq_pkg::CMD_POP_FRONT: begin
				if (mdl_count == 0) begin
					r.st = bdq_pkg::STAT_UNDERFLOW;
				end else begin
					mdl_head = mdl_head + 1'b1;
					mdl_count--;
				end
			end
			bdq_pkg::CMD_READ: begin
				if (p >= mdl_count) begin
					r.st = bdq_pkg::STAT_RANGE;
				end else begin
					slot = mdl_head + p;
					r.rd = ring[slot];
				end
			end
			default: ;
		endcase
		if (mdl_count == 0) begin
			r.front = '0;
			r.back  = '0;
		end else begin
			slot = mdl_head + mdl_count[bdq_pkg::POS_W-1:0] - 1'b1;
			r.front = ring[mdl_head];
			r.back  = ring[slot];
		end
		r.cnt   = mdl_count;
		r.empty = (mdl_count == 0);
		if (int'(mdl_count) > peak_count) peak_count = int'(mdl_count);
		return r;
	endfunction

	// Offer one beat, wait for it to be taken, then log its expected result.
	task automatic send_command(input logic [bdq_pkg::CMD_W-1:0] c,
			input logic signed [DATA_WIDTH-1:0] d, input logic [bdq_pkg::POS_W-1:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		data     <= d;
		position <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.insert(pending_results.size(), deque_step(c, d, p));
		commands_sent++;
	endtask

	function automatic logic signed [DATA_WIDTH-1:0] random_word();
		case ($urandom_range(15))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [bdq_pkg::POS_W-1:0] random_pos_bits();
		return bdq_pkg::POS_W'($urandom);
	endfunction

	function automatic logic [bdq_pkg::POS_W-1:0] random_position();
		if (mdl_count > 0 && $urandom_range(1))
			return bdq_pkg::POS_W'($urandom_range(mdl_count - 1, 0));
		return bdq_pkg::POS_W'($urandom_range(DEPTH - 1, 0));
	endfunction

	function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %0d, got %0d", name, $signed(expv), $signed(actv));
			fail_count++;
		end
	endfunction

	task automatic check_result();
		deque_result_t e;
		if (pending_results.size() == 0) begin
			$error("result beat with no command outstanding");
			fail_count++;
		end else begin
			e = pending_results[0];
			pending_results.delete(0);
			check_field("read_value", e.rd, read_value);
			check_field("front_value", e.front, front_value);
			check_field("back_value", e.back, back_value);
			check_field("entry_count", 32'(e.cnt), 32'(entry_count));
			check_field("is_empty", 32'(e.empty), 32'(is_empty));
			check_field("status", 32'(e.st), 32'(status));
			status_seen[e.st]++;
			results_checked++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) check_result();
	end

	// Receiver: random stall, or a long hold when requested.
	initial begin
		out_stall   = 1'b0;
		hold_left   = 0;
		holds_taken = 0;
		forever begin
			@(posedge clk);
			if (holds_taken != hold_requests) begin
				holds_taken = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic test_directed_edges();
		logic [bdq_pkg::CMD_W:0] c;
		send_command(bdq_pkg::CMD_POP_BACK, $urandom, random_pos_bits());
		send_command(bdq_pkg::CMD_POP_FRONT, $urandom, random_pos_bits());
		send_command(bdq_pkg::CMD_READ, $urandom, '0);
		send_command(bdq_pkg::CMD_READ, $urandom, '1);
		for (c = {1'b0, CMD_UNUSED_FIRST}; c <= {1'b0, CMD_UNUSED_LAST}; c++)
			send_command(c[bdq_pkg::CMD_W-1:0], $urandom, random_pos_bits());
		send_command(bdq_pkg::CMD_PUSH_BACK, WORD_MAX, '1);
		send_command(bdq_pkg::CMD_PUSH_FRONT, WORD_MIN, '1);
		send_command(bdq_pkg::CMD_PUSH_BACK, '0, '0);
		send_command(bdq_pkg::CMD_PUSH_FRONT, -1, '0);
		for (int i = 0; i < 4; i++)
			send_command(bdq_pkg::CMD_READ, $urandom, bdq_pkg::POS_W'(i));
		send_command(bdq_pkg::CMD_READ, $urandom, bdq_pkg::POS_W'(4));
		send_command(bdq_pkg::CMD_READ, $urandom, '1);
		send_command(CMD_UNUSED_FIRST, WORD_MAX, '0);
		send_command(bdq_pkg::CMD_POP_BACK, $urandom, random_pos_bits());
		send_command(bdq_pkg::CMD_POP_FRONT, $urandom, random_pos_bits());
		send_command(bdq_pkg::CMD_READ, $urandom, '0);
		send_command(bdq_pkg::CMD_POP_BACK, $urandom, random_pos_bits());
		send_command(bdq_pkg::CMD_POP_FRONT, $urandom, random_pos_bits());
		send_command(bdq_pkg::CMD_POP_FRONT, $urandom, random_pos_bits());
	endtask

	task automatic test_fill_and_overflow();
		while (mdl_count < DEPTH)
			send_command($urandom_range(1) ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK,
				random_word(), random_pos_bits());
		send_command(bdq_pkg::CMD_PUSH_BACK, random_word(), random_pos_bits());
		send_command(bdq_pkg::CMD_PUSH_FRONT, random_word(), random_pos_bits());
		send_command(bdq_pkg::CMD_READ, $urandom, '1);
		send_command(bdq_pkg::CMD_READ, $urandom, '0);
		// Drain with reads mixed in, then pop once more past empty.
		while (mdl_count > 0) begin
			if ($urandom_range(3) == 0)
				send_command(bdq_pkg::CMD_READ, $urandom, random_position());
			else
				send_command($urandom_range(1) ? bdq_pkg::CMD_POP_FRONT : bdq_pkg::CMD_POP_BACK,
					$urandom, random_pos_bits());
		end
		send_command(bdq_pkg::CMD_POP_BACK, $urandom, random_pos_bits());
	endtask

	task automatic random_command(input int push_pct);
		int r;
		logic [bdq_pkg::CMD_W-1:0] c;
		r = $urandom_range(99);
		if (r < 3) begin
			c = bdq_pkg::CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
		end else if (r < 25) begin
			c = bdq_pkg::CMD_READ;
		end else if ($urandom_range(99) < push_pct) begin
			c = $urandom_range(1) ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK;
		end else begin
			c = $urandom_range(1) ? bdq_pkg::CMD_POP_FRONT : bdq_pkg::CMD_POP_BACK;
		end
		send_command(c, random_word(), random_position());
	endtask

	task automatic test_output_backpressure();
		hold_requests++;
		for (int i = 0; i < 30; i++) random_command(60);
	endtask

	task automatic test_random_traffic(input int n);
		int push_pct;
		push_pct = 50;
		for (int i = 0; i < n; i++) begin
			// Swing the push rate so the count sweeps between empty and full.
			if (i % 80 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 85;
					1: push_pct = 15;
					default: push_pct = 50;
				endcase
			end
			random_command(push_pct);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = bdq_pkg::CMD_PUSH_BACK;
		data          = '0;
		position      = '0;
		mdl_head      = '0;
		mdl_count     = '0;
		send_idle_pct = 9;
		recv_idle_pct = 56;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_fill_and_overflow();
		test_output_backpressure();
		test_random_traffic(330);
		send_idle_pct = 56;
		recv_idle_pct = 9;
		test_random_traffic(330);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(330);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d commands and checked %0d results; deque reached %0d of %0d entries.",
			commands_sent, results_checked, peak_count, DEPTH);
		$display("Result status: %0d ok, %0d underflow, %0d out of range, %0d overflow.",
			status_seen[bdq_pkg::STAT_OK], status_seen[bdq_pkg::STAT_UNDERFLOW],
			status_seen[bdq_pkg::STAT_RANGE], status_seen[bdq_pkg::STAT_OVERFLOW]);
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
